// ===== rtl/ntcc_pkg.sv =====
package ntcc_pkg;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_LINK1  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LINK2  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LINK3  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_THRESH = 2'd3;

    localparam logic [15:0] LINK1_RST  = 16'd5898;
    localparam logic [15:0] LINK2_RST  = 16'd5898;
    localparam logic [15:0] LINK3_RST  = 16'd3473;
    localparam logic [15:0] THRESH_RST = 16'd410;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [16:0] PHASE_MUL = 17'd83443;
    localparam logic [30:0] SIN_A1 = 31'd1686629713;
    localparam logic [30:0] SIN_A3 = 31'd693598668;
    localparam logic [30:0] SIN_A5 = 31'd85569306;
    localparam logic [30:0] SIN_A7 = 31'd5026995;
    localparam logic [30:0] SIN_A9 = 31'd172272;

    typedef struct packed {
        logic signed [17:0] ang1;
        logic signed [17:0] ang12;
        logic signed [17:0] ang123;
        logic signed [15:0] tau0;
        logic signed [15:0] tau1;
        logic signed [15:0] tau2;
    } t_item;

    typedef struct packed {
        logic [15:0] link1;
        logic [15:0] link2;
        logic [15:0] link3;
        logic [15:0] thresh;
    } t_cfg;

endpackage

// ===== rtl/ntcc_front.sv =====
module ntcc_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [95:0]          i_data,
    output logic                 o_valid,
    input  logic                 i_ready,
    output ntcc_pkg::t_item      o_item
);
    logic            r_valid;
    ntcc_pkg::t_item r_item;
    ntcc_pkg::t_item n_item;

    logic signed [17:0] a1, a2, a3;

    assign a1 = {{2{i_data[15]}}, i_data[15:0]};
    assign a2 = {{2{i_data[31]}}, i_data[31:16]};
    assign a3 = {{2{i_data[47]}}, i_data[47:32]};

    // cumulative joint angles
    always_comb begin
        n_item.ang1   = a1;
        n_item.ang12  = a1 + a2;
        n_item.ang123 = a1 + a2 + a3;
        n_item.tau0   = i_data[63:48];
        n_item.tau1   = i_data[79:64];
        n_item.tau2   = i_data[95:80];
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end
endmodule

// ===== rtl/ntcc_queue.sv =====
module ntcc_queue #(
    parameter int DEPTH = ntcc_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  ntcc_pkg::t_item i_item,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output ntcc_pkg::t_item o_item
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    ntcc_pkg::t_item r_mem [DEPTH];
    logic [PW-1:0]   r_wp, r_rp;
    logic [CW-1:0]   r_cnt;
    logic            do_push, do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_item;
        end
    end
endmodule

// ===== rtl/ntcc_back.sv =====
module ntcc_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  ntcc_pkg::t_cfg  i_cfg,
    input  logic            i_empty,
    input  ntcc_pkg::t_item i_item,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [15:0]     o_norm,
    output logic            o_coll,
    output logic            o_sing
);
    localparam logic [4:0] ST_IDLE  = 5'd0;
    localparam logic [4:0] ST_PHASE = 5'd1;
    localparam logic [4:0] ST_SZ    = 5'd2;
    localparam logic [4:0] ST_SZ2   = 5'd3;
    localparam logic [4:0] ST_SHORN = 5'd4;
    localparam logic [4:0] ST_SFIN  = 5'd5;
    localparam logic [4:0] ST_JMUL  = 5'd6;
    localparam logic [4:0] ST_JSUM  = 5'd7;
    localparam logic [4:0] ST_NMUL  = 5'd8;
    localparam logic [4:0] ST_MAG   = 5'd9;
    localparam logic [4:0] ST_NORM  = 5'd10;
    localparam logic [4:0] ST_DOT   = 5'd11;
    localparam logic [4:0] ST_SQRT  = 5'd12;
    localparam logic [4:0] ST_PREP  = 5'd13;
    localparam logic [4:0] ST_DIV   = 5'd14;
    localparam logic [4:0] ST_FIN   = 5'd15;
    localparam logic [4:0] ST_DONE  = 5'd16;

    localparam logic [16:0] PHASE_MUL_W = ntcc_pkg::PHASE_MUL;

    logic [4:0] r_state;
    logic [2:0] r_idx;
    logic [1:0] r_h;
    logic [5:0] r_it;

    logic signed [17:0] r_ang [3];
    logic signed [15:0] r_tau [3];
    logic [31:0]        r_ph  [3];
    logic [30:0]        r_z, r_z2, r_t;
    logic [1:0]         r_quad;
    logic signed [15:0] r_sn  [3];
    logic signed [15:0] r_cs  [3];
    logic signed [31:0] r_pa  [6];
    logic signed [18:0] r_j   [6];
    logic signed [38:0] r_acc;
    logic signed [38:0] r_n   [3];
    logic [37:0]        r_mag [3];
    logic               r_neg [3];
    logic [37:0]        r_mx;
    logic signed [46:0] r_dot;
    logic [57:0]        r_nn;
    logic [30:0]        r_rem;
    logic [28:0]        r_root;
    logic [45:0]        r_num;
    logic [28:0]        r_drem;
    logic [15:0]        r_norm;
    logic               r_coll, r_sing;

    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] prod;

    function automatic logic signed [18:0] rs14(input logic signed [33:0] x);
        logic [33:0] m;
        logic [33:0] m2;
        m  = x[33] ? 34'(-x) : 34'(x);
        m2 = (m + 34'd8192) >> 14;
        return x[33] ? -$signed(m2[18:0]) : $signed(m2[18:0]);
    endfunction

    assign prod = mul_a * mul_b;

    logic signed [15:0] jm_trig;
    logic [15:0]        jm_len;
    logic signed [18:0] nm_a, nm_b;
    logic [27:0]        dm_mag;
    logic               dm_neg;
    logic signed [15:0] dm_tau;
    logic signed [28:0] dm_c;

    always_comb begin
        jm_len  = i_cfg.link1;
        jm_trig = r_sn[0];
        case (r_idx)
            3'd0: begin jm_len = i_cfg.link1; jm_trig = r_sn[0]; end
            3'd1: begin jm_len = i_cfg.link2; jm_trig = r_sn[1]; end
            3'd2: begin jm_len = i_cfg.link3; jm_trig = r_sn[2]; end
            3'd3: begin jm_len = i_cfg.link1; jm_trig = r_cs[0]; end
            3'd4: begin jm_len = i_cfg.link2; jm_trig = r_cs[1]; end
            default: begin jm_len = i_cfg.link3; jm_trig = r_cs[2]; end
        endcase
        // cross product pairs: n0 = j01*j12 - j02*j11 and so on
        case (r_idx)
            3'd0: begin nm_a = r_j[1]; nm_b = r_j[5]; end
            3'd1: begin nm_a = r_j[2]; nm_b = r_j[4]; end
            3'd2: begin nm_a = r_j[2]; nm_b = r_j[3]; end
            3'd3: begin nm_a = r_j[0]; nm_b = r_j[5]; end
            3'd4: begin nm_a = r_j[0]; nm_b = r_j[4]; end
            default: begin nm_a = r_j[1]; nm_b = r_j[3]; end
        endcase
        case (r_idx)
            3'd0, 3'd3: begin dm_mag = r_mag[0][27:0]; dm_neg = r_neg[0]; dm_tau = r_tau[0]; end
            3'd1, 3'd4: begin dm_mag = r_mag[1][27:0]; dm_neg = r_neg[1]; dm_tau = r_tau[1]; end
            default:    begin dm_mag = r_mag[2][27:0]; dm_neg = r_neg[2]; dm_tau = r_tau[2]; end
        endcase
        dm_c = dm_neg ? -$signed({1'b0, dm_mag}) : $signed({1'b0, dm_mag});
    end

    logic signed [17:0] ph_ang;
    always_comb begin
        case (r_idx)
            3'd0:    ph_ang = r_ang[0];
            3'd1:    ph_ang = r_ang[1];
            default: ph_ang = r_ang[2];
        endcase
    end

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            ST_PHASE: begin
                mul_a = 33'(ph_ang);
                mul_b = $signed({16'b0, PHASE_MUL_W});
            end
            ST_SZ2: begin
                mul_a = $signed({2'b0, r_z});
                mul_b = $signed({2'b0, r_z});
            end
            ST_SHORN: begin
                mul_a = $signed({2'b0, r_t});
                mul_b = $signed({2'b0, r_z2});
            end
            ST_SFIN: begin
                mul_a = $signed({2'b0, r_t});
                mul_b = $signed({2'b0, r_z});
            end
            ST_JMUL: begin
                mul_a = $signed({17'b0, jm_len});
                mul_b = 33'(jm_trig);
            end
            ST_NMUL: begin
                mul_a = 33'(nm_a);
                mul_b = 33'(nm_b);
            end
            ST_DOT: begin
                if (r_idx < 3'd3) begin
                    mul_a = 33'(dm_c);
                    mul_b = 33'(dm_tau);
                end else begin
                    mul_a = $signed({5'b0, dm_mag});
                    mul_b = $signed({5'b0, dm_mag});
                end
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // sine argument
    logic [31:0] sz_ph;
    logic [29:0] sz_f;
    assign sz_ph = r_ph[r_idx[2:1]] + (r_idx[0] ? 32'h4000_0000 : 32'h0);
    assign sz_f  = sz_ph[29:0];

    logic [30:0] horn_c;
    logic [32:0] horn_t;
    always_comb begin
        case (r_h)
            2'd0:    horn_c = ntcc_pkg::SIN_A7;
            2'd1:    horn_c = ntcc_pkg::SIN_A5;
            2'd2:    horn_c = ntcc_pkg::SIN_A3;
            default: horn_c = ntcc_pkg::SIN_A1;
        endcase
        horn_t = {2'b0, horn_c} - prod[62:30];
    end

    logic [33:0]        sf_r;
    logic [17:0]        sf_s;
    logic signed [15:0] sf_trig;
    always_comb begin
        sf_r    = {1'b0, prod[62:30]} + 34'd32768;
        sf_s    = sf_r[33:16];
        if (sf_s > 18'd16384) begin
            sf_s = 18'd16384;
        end
        sf_trig = r_quad[1] ? -$signed(sf_s[15:0]) : $signed(sf_s[15:0]);
    end

    logic signed [33:0] sa3, sa23, sb3, sb23, sa123, sb123;
    assign sa3   = 34'(r_pa[2]);
    assign sa23  = 34'(r_pa[1]) + 34'(r_pa[2]);
    assign sa123 = 34'(r_pa[0]) + sa23;
    assign sb3   = 34'(r_pa[5]);
    assign sb23  = 34'(r_pa[4]) + 34'(r_pa[5]);
    assign sb123 = 34'(r_pa[3]) + sb23;

    logic [37:0] mg [3];
    logic [37:0] mg_mx;
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            mg[i] = r_n[i][38] ? 38'(-r_n[i]) : 38'(r_n[i]);
        end
        mg_mx = mg[0];
        if (mg[1] > mg_mx) mg_mx = mg[1];
        if (mg[2] > mg_mx) mg_mx = mg[2];
    end

    logic [32:0] sq_rem2;
    logic [30:0] sq_trial;
    logic        sq_ge;
    assign sq_rem2  = {r_rem, r_nn[57:56]};
    assign sq_trial = {r_root, 2'b01};
    assign sq_ge    = sq_rem2 >= {2'b0, sq_trial};

    logic [29:0] dv_rem2;
    logic        dv_ge;
    logic [29:0] dv_sub;
    assign dv_rem2 = {r_drem, r_num[45]};
    assign dv_ge   = dv_rem2 >= {1'b0, r_root};
    assign dv_sub  = dv_rem2 - {1'b0, r_root};

    logic [45:0] pr_ad;
    assign pr_ad = r_dot[46] ? 46'(-r_dot) : 46'(r_dot);

    assign o_pop   = (r_state == ST_IDLE) && !i_empty;
    assign o_valid = (r_state == ST_DONE);
    assign o_norm  = r_norm;
    assign o_coll  = r_coll;
    assign o_sing  = r_sing;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
            r_h     <= '0;
            r_it    <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (!i_empty) begin
                        r_state <= ST_PHASE;
                        r_idx   <= '0;
                    end
                end
                ST_PHASE: begin
                    if (r_idx == 3'd2) begin
                        r_idx   <= '0;
                        r_state <= ST_SZ;
                    end else begin
                        r_idx <= r_idx + 3'd1;
                    end
                end
                ST_SZ:  r_state <= ST_SZ2;
                ST_SZ2: begin
                    r_h     <= '0;
                    r_state <= ST_SHORN;
                end
                ST_SHORN: begin
                    r_h <= r_h + 2'd1;
                    if (r_h == 2'd3) begin
                        r_state <= ST_SFIN;
                    end
                end
                ST_SFIN: begin
                    if (r_idx == 3'd5) begin
                        r_idx   <= '0;
                        r_state <= ST_JMUL;
                    end else begin
                        r_idx   <= r_idx + 3'd1;
                        r_state <= ST_SZ;
                    end
                end
                ST_JMUL: begin
                    if (r_idx == 3'd5) begin
                        r_state <= ST_JSUM;
                    end else begin
                        r_idx <= r_idx + 3'd1;
                    end
                end
                ST_JSUM: begin
                    r_idx   <= '0;
                    r_state <= ST_NMUL;
                end
                ST_NMUL: begin
                    if (r_idx == 3'd5) begin
                        r_state <= ST_MAG;
                    end else begin
                        r_idx <= r_idx + 3'd1;
                    end
                end
                ST_MAG: begin
                    r_state <= (mg_mx == '0) ? ST_DONE : ST_NORM;
                end
                ST_NORM: begin
                    if (r_mx[37:28] == '0 && r_mx[27]) begin
                        r_idx   <= '0;
                        r_state <= ST_DOT;
                    end
                end
                ST_DOT: begin
                    if (r_idx == 3'd5) begin
                        r_it    <= 6'd28;
                        r_state <= ST_SQRT;
                    end else begin
                        r_idx <= r_idx + 3'd1;
                    end
                end
                ST_SQRT: begin
                    r_it <= r_it - 6'd1;
                    if (r_it == '0) begin
                        r_state <= ST_PREP;
                    end
                end
                ST_PREP: begin
                    r_it    <= 6'd45;
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    r_it <= r_it - 6'd1;
                    if (r_it == '0) begin
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN:  r_state <= ST_DONE;
                ST_DONE: begin
                    if (i_ready) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_ang[0] <= i_item.ang1;
                r_ang[1] <= i_item.ang12;
                r_ang[2] <= i_item.ang123;
                r_tau[0] <= i_item.tau0;
                r_tau[1] <= i_item.tau1;
                r_tau[2] <= i_item.tau2;
            end
            ST_PHASE: r_ph[r_idx[1:0]] <= prod[31:0];
            ST_SZ: begin
                r_quad <= sz_ph[31:30];
                r_z    <= sz_ph[30] ? (31'h4000_0000 - {1'b0, sz_f}) : {1'b0, sz_f};
            end
            ST_SZ2: begin
                r_z2 <= prod[60:30];
                r_t  <= ntcc_pkg::SIN_A9;
            end
            ST_SHORN: r_t <= horn_t[30:0];
            ST_SFIN: begin
                if (r_idx[0]) begin
                    r_cs[r_idx[2:1]] <= sf_trig;
                end else begin
                    r_sn[r_idx[2:1]] <= sf_trig;
                end
            end
            ST_JMUL: r_pa[r_idx] <= prod[31:0];
            ST_JSUM: begin
                r_j[0] <= rs14(-sa123);
                r_j[1] <= rs14(-sa23);
                r_j[2] <= rs14(-sa3);
                r_j[3] <= rs14(sb123);
                r_j[4] <= rs14(sb23);
                r_j[5] <= rs14(sb3);
            end
            ST_NMUL: begin
                if (!r_idx[0]) begin
                    r_acc <= prod[38:0];
                end else begin
                    r_n[r_idx[2:1]] <= r_acc - prod[38:0];
                end
            end
            ST_MAG: begin
                for (int i = 0; i < 3; i++) begin
                    r_mag[i] <= mg[i];
                    r_neg[i] <= r_n[i][38];
                end
                r_mx   <= mg_mx;
                r_dot  <= '0;
                r_nn   <= '0;
                r_norm <= '0;
                r_coll <= 1'b0;
                r_sing <= 1'b1;
            end
            ST_NORM: begin
                if (r_mx[37:28] != '0) begin
                    r_mx <= r_mx >> 1;
                    for (int i = 0; i < 3; i++) r_mag[i] <= r_mag[i] >> 1;
                end else if (!r_mx[27]) begin
                    r_mx <= r_mx << 1;
                    for (int i = 0; i < 3; i++) r_mag[i] <= r_mag[i] << 1;
                end
            end
            ST_DOT: begin
                if (r_idx < 3'd3) begin
                    r_dot <= r_dot + prod[46:0];
                end else begin
                    r_nn <= r_nn + {2'b0, prod[55:0]};
                end
                r_rem  <= '0;
                r_root <= '0;
            end
            ST_SQRT: begin
                r_nn <= r_nn << 2;
                if (sq_ge) begin
                    r_rem  <= 31'(sq_rem2 - {2'b0, sq_trial});
                    r_root <= {r_root[27:0], 1'b1};
                end else begin
                    r_rem  <= sq_rem2[30:0];
                    r_root <= {r_root[27:0], 1'b0};
                end
            end
            ST_PREP: begin
                r_num  <= pr_ad + {18'b0, r_root[28:1]};
                r_drem <= '0;
            end
            ST_DIV: begin
                r_drem <= dv_ge ? dv_sub[28:0] : dv_rem2[28:0];
                r_num  <= {r_num[44:0], dv_ge};
            end
            ST_FIN: begin
                r_norm <= (r_num[45:16] != '0) ? 16'hFFFF : r_num[15:0];
                r_coll <= r_num > {30'b0, i_cfg.thresh};
                r_sing <= 1'b0;
            end
            default: begin
            end
        endcase
    end
endmodule

// ===== rtl/nullspace_torque_collision_check_top.sv =====
// Timing: input-to-result delay varies with the normalize step and with output stalls;
// singular samples skip normalize onward and finish sooner. The back end runs
// one shared 33x33 multiplier, a 29-step square root and a 46-step restoring divider.
// The front stage and a two-entry queue keep accepting while the back end works or its
// result waits, until the queue fills; the back end holds one sample at a time.
// Reset: i_rst_n synchronous active low; restores link lengths and threshold, empties pipe.
module nullspace_torque_collision_check_top #(
    parameter int QDEPTH = ntcc_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // angle_one, angle_two, angle_three, torque_one, torque_two, torque_three
    input  logic [95:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // residual_norm, collision, singular, zero pad
    output logic [23:0] m_axis_tdata,
    input  logic        i_cfg_we,
    input  logic [ntcc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [15:0] i_cfg_wdata
);
    ntcc_pkg::t_cfg  r_cfg;
    ntcc_pkg::t_item f_item, q_item;
    logic            f_valid, q_full, q_empty, q_pop;
    logic [15:0]     b_norm;
    logic            b_coll, b_sing;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.link1  <= ntcc_pkg::LINK1_RST;
            r_cfg.link2  <= ntcc_pkg::LINK2_RST;
            r_cfg.link3  <= ntcc_pkg::LINK3_RST;
            r_cfg.thresh <= ntcc_pkg::THRESH_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                ntcc_pkg::REG_LINK1:  r_cfg.link1  <= i_cfg_wdata;
                ntcc_pkg::REG_LINK2:  r_cfg.link2  <= i_cfg_wdata;
                ntcc_pkg::REG_LINK3:  r_cfg.link3  <= i_cfg_wdata;
                ntcc_pkg::REG_THRESH: r_cfg.thresh <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    ntcc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_data  (s_axis_tdata),
        .o_valid (f_valid),
        .i_ready (!q_full),
        .o_item  (f_item)
    );

    ntcc_queue #(.DEPTH(QDEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid),
        .i_item  (f_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_item  (q_item)
    );

    ntcc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_empty (q_empty),
        .i_item  (q_item),
        .o_pop   (q_pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_norm  (b_norm),
        .o_coll  (b_coll),
        .o_sing  (b_sing)
    );

    assign m_axis_tdata = {6'b0, b_sing, b_coll, b_norm};
endmodule

// ===== bench/tb_nullspace_torque_collision_check_top.sv =====
module tb_nullspace_torque_collision_check_top;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [15:0] norm;
        logic        coll;
        logic        sing;
    } t_verdict;

    typedef struct {
        logic [15:0] a1, a2, a3, q1, q2, q3;
        bit          typed;
        logic [15:0] norm;
        logic        coll;
        logic        sing;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic        i_cfg_we = 1'b0;
    logic [ntcc_pkg::CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [15:0] i_cfg_wdata = '0;

    logic [15:0] len1, len2, len3, thresh;
    t_verdict    pending[$];
    int          n_err = 0;
    int          n_beats_in = 0;
    int          n_beats_out = 0;
    int          n_sing = 0;
    int          n_coll = 0;
    int          n_sat = 0;
    longint      cycles = 0;
    bit          hold_off = 1'b0;

    nullspace_torque_collision_check_top DUT (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 1500000) begin
            $display("tb_nullspace_torque_collision_check_top: errors");
            $finish;
        end
    end

    function automatic longint sin_q14(logic [31:0] ph);
        logic [1:0]   quad;
        longint unsigned f, z, z2, t, s;
        quad = ph[31:30];
        f = ph[29:0];
        z = quad[0] ? (64'd1 << 30) - f : f;
        z2 = (z * z) >> 30;
        t = ntcc_pkg::SIN_A9;
        t = ntcc_pkg::SIN_A7 - ((t * z2) >> 30);
        t = ntcc_pkg::SIN_A5 - ((t * z2) >> 30);
        t = ntcc_pkg::SIN_A3 - ((t * z2) >> 30);
        t = ntcc_pkg::SIN_A1 - ((t * z2) >> 30);
        s = (t * z) >> 30;
        s = (s + 32768) >> 16;
        if (s > 16384) s = 16384;
        return quad[1] ? -longint'(s) : longint'(s);
    endfunction

    function automatic longint rnd14(longint x);
        longint unsigned m;
        m = x < 0 ? -x : x;
        m = (m + 8192) >> 14;
        return x < 0 ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic t_verdict project_torque(logic [95:0] d);
        t_verdict v;
        longint th[3], tq[3], sn[3], cs[3], j0[3], j1[3], n[3], lens[3], dotp;
        longint unsigned mag[3], mx, nn, r, ad, nrm;
        logic [31:0] ph;
        th[0] = $signed(d[15:0]);
        th[1] = th[0] + $signed(d[31:16]);
        th[2] = th[1] + $signed(d[47:32]);
        tq[0] = $signed(d[63:48]);
        tq[1] = $signed(d[79:64]);
        tq[2] = $signed(d[95:80]);
        lens[0] = len1; lens[1] = len2; lens[2] = len3;
        for (int i = 0; i < 3; i++) begin
            ph = th[i] * 64'd83443;
            sn[i] = lens[i] * sin_q14(ph);
            cs[i] = lens[i] * sin_q14(ph + 32'h4000_0000);
        end
        j0[0] = rnd14(-(sn[0] + sn[1] + sn[2]));
        j0[1] = rnd14(-(sn[1] + sn[2]));
        j0[2] = rnd14(-sn[2]);
        j1[0] = rnd14(cs[0] + cs[1] + cs[2]);
        j1[1] = rnd14(cs[1] + cs[2]);
        j1[2] = rnd14(cs[2]);
        n[0] = j0[1] * j1[2] - j0[2] * j1[1];
        n[1] = j0[2] * j1[0] - j0[0] * j1[2];
        n[2] = j0[0] * j1[1] - j0[1] * j1[0];
        mx = 0;
        for (int i = 0; i < 3; i++) begin
            mag[i] = n[i] < 0 ? -n[i] : n[i];
            if (mag[i] > mx) mx = mag[i];
        end
        if (mx == 0) begin
            v.norm = 0; v.coll = 0; v.sing = 1;
            return v;
        end
        while (mx >= (64'd1 << 28)) begin
            mx >>= 1;
            for (int i = 0; i < 3; i++) mag[i] >>= 1;
        end
        while (mx < (64'd1 << 27)) begin
            mx <<= 1;
            for (int i = 0; i < 3; i++) mag[i] <<= 1;
        end
        dotp = 0;
        nn = 0;
        for (int i = 0; i < 3; i++) begin
            dotp += (n[i] < 0 ? -longint'(mag[i]) : longint'(mag[i])) * tq[i];
            nn += mag[i] * mag[i];
        end
        r = root_floor(nn);
        ad = dotp < 0 ? -dotp : dotp;
        nrm = (ad + r / 2) / r;
        v.norm = nrm > 65535 ? 16'hFFFF : nrm[15:0];
        v.coll = nrm > thresh;
        v.sing = 0;
        return v;
    endfunction

    task automatic write_reg(logic [ntcc_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            ntcc_pkg::REG_LINK1: len1 = val;
            ntcc_pkg::REG_LINK2: len2 = val;
            ntcc_pkg::REG_LINK3: len3 = val;
            ntcc_pkg::REG_THRESH: thresh = val;
            default: begin
            end
        endcase
        @(posedge i_clk);
    endtask

    task automatic drain;
        while (pending.size() != 0) @(posedge i_clk);
        repeat (250) @(posedge i_clk);
    endtask

    // one beat; optional typed expectation overrides predictor
    task automatic send_sample(logic [95:0] d, bit typed = 0, t_verdict tv = '{0, 0, 0});
        t_verdict v;
        v = project_torque(d);
        if (typed && v != tv) begin
            $error("table row for %h: verdict exp %h predictor %h", d, tv, v);
            n_err++;
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= d;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pending.push_back(typed ? tv : v);
        n_beats_in++;
        if (v.sing) n_sing++;
    endtask

    function automatic logic [15:0] pick16();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'($urandom_range(0, 600)) - 16'd300;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_burst(int count, bit small_tau);
        logic [95:0] d;
        int left;
        left = count;
        while (left > 0) begin
            for (int k = $urandom_range(1, 12); k > 0 && left > 0; k--) begin
                d = {$urandom, $urandom, $urandom};
                if ($urandom_range(0, 3) == 0) d[47:0] = {pick16(), pick16(), pick16()};
                if (small_tau) d[95:48] = {16'($signed(d[95:80]) >>> 6),
                                           16'($signed(d[79:64]) >>> 6),
                                           16'($signed(d[63:48]) >>> 6)};
                send_sample(d);
                left--;
            end
            if ($urandom_range(0, 2) != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 300)) @(posedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            t_verdict got, want;
            got.norm = m_axis_tdata[15:0];
            got.coll = m_axis_tdata[16];
            got.sing = m_axis_tdata[17];
            if (pending.size() == 0) begin
                $error("result beat with nothing expected: %h", m_axis_tdata);
                n_err++;
            end else begin
                want = pending.pop_front();
                n_beats_out++;
                if (got.coll) n_coll++;
                if (got.norm == 16'hFFFF) n_sat++;
                if (got.norm !== want.norm) begin
                    $error("residual_norm exp %0d got %0d", want.norm, got.norm);
                    n_err++;
                end
                if (got.coll !== want.coll) begin
                    $error("collision exp %0d got %0d", want.coll, got.coll);
                    n_err++;
                end
                if (got.sing !== want.sing) begin
                    $error("singular exp %0d got %0d", want.sing, got.sing);
                    n_err++;
                end
                if (m_axis_tdata[23:18] !== 6'd0) begin
                    $error("pad exp 0 got %h", m_axis_tdata[23:18]);
                    n_err++;
                end
            end
        end
    end

    // receiver stall pattern, plus a long hold-off on request
    always @(posedge i_clk) begin
        int phase_cnt;
        phase_cnt = int'(cycles % 97);
        if (hold_off)
            m_axis_tready <= 1'b0;
        else if (phase_cnt < 30)
            m_axis_tready <= 1'b1;
        else
            m_axis_tready <= ($urandom_range(0, 3) != 0);
    end

    t_row rows[] = '{
        '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1, 16'd0, 1'b0, 1'b1},
        '{16'h0000, 16'h0000, 16'h0000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1, 16'd0, 1'b0, 1'b1},
        '{16'h1234, 16'h0000, 16'h0000, 16'h8000, 16'h8000, 16'h8000, 0, 0, 0, 0},
        '{16'h0000, 16'h0C90, 16'h0C90, 16'h0000, 16'h0000, 16'h0000, 0, 0, 0, 0},
        '{16'h0000, 16'h0C90, 16'h0C90, 16'h7FFF, 16'h8000, 16'h7FFF, 0, 0, 0, 0},
        '{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 0, 0, 0, 0},
        '{16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 0, 0, 0, 0},
        '{16'h8000, 16'h7FFF, 16'h0001, 16'h0100, 16'hFF00, 16'h0100, 0, 0, 0, 0},
        '{16'h1000, 16'hF000, 16'h0800, 16'h0010, 16'h0020, 16'h0030, 0, 0, 0, 0},
        '{16'h0400, 16'h0400, 16'h0400, 16'h1000, 16'h1000, 16'h1000, 0, 0, 0, 0},
        '{16'h3244, 16'h1922, 16'hE6DE, 16'h0199, 16'hFE67, 16'h0001, 0, 0, 0, 0},
        '{16'hFFFF, 16'h0001, 16'hFFFF, 16'h5555, 16'hAAAA, 16'h5555, 0, 0, 0, 0}
    };

    initial begin
        len1 = ntcc_pkg::LINK1_RST;
        len2 = ntcc_pkg::LINK2_RST;
        len3 = ntcc_pkg::LINK3_RST;
        thresh = ntcc_pkg::THRESH_RST;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i])
            send_sample({rows[i].q3, rows[i].q2, rows[i].q1, rows[i].a3, rows[i].a2, rows[i].a1},
                        rows[i].typed, '{rows[i].norm, rows[i].coll, rows[i].sing});
        s_axis_tvalid <= 1'b0;
        drain();

        // all-zero links: always singular
        write_reg(ntcc_pkg::REG_LINK1, 16'h0000);
        write_reg(ntcc_pkg::REG_LINK2, 16'h0000);
        write_reg(ntcc_pkg::REG_LINK3, 16'h0000);
        write_reg(ntcc_pkg::REG_THRESH, 16'h0000);
        send_sample({16'h7FFF, 16'h8000, 16'h7FFF, 16'h1111, 16'h2222, 16'h3333},
                    1, '{16'd0, 1'b0, 1'b1});
        s_axis_tvalid <= 1'b0;
        drain();

        write_reg(ntcc_pkg::REG_LINK1, 16'hFFFF);
        write_reg(ntcc_pkg::REG_LINK2, 16'hFFFF);
        write_reg(ntcc_pkg::REG_LINK3, 16'hFFFF);
        write_reg(ntcc_pkg::REG_THRESH, 16'hFFFF);
        random_burst(120, 0);
        drain();

        // long receiver hold-off while the sender keeps offering
        fork
            begin
                hold_off = 1'b1;
                repeat (3000) @(posedge i_clk);
                hold_off = 1'b0;
            end
            random_burst(30, 0);
        join
        drain();

        write_reg(ntcc_pkg::REG_LINK1, ntcc_pkg::LINK1_RST);
        write_reg(ntcc_pkg::REG_LINK2, ntcc_pkg::LINK2_RST);
        write_reg(ntcc_pkg::REG_LINK3, ntcc_pkg::LINK3_RST);
        write_reg(ntcc_pkg::REG_THRESH, ntcc_pkg::THRESH_RST);
        random_burst(150, 1);
        drain();

        write_reg(ntcc_pkg::REG_LINK1, 16'($urandom));
        write_reg(ntcc_pkg::REG_LINK2, 16'h0001);
        write_reg(ntcc_pkg::REG_LINK3, 16'($urandom));
        write_reg(ntcc_pkg::REG_THRESH, 16'($urandom_range(0, 4000)));
        random_burst(120, 1);
        drain();

        write_reg(ntcc_pkg::REG_LINK1, 16'($urandom));
        write_reg(ntcc_pkg::REG_LINK2, 16'($urandom));
        write_reg(ntcc_pkg::REG_LINK3, 16'h0000);
        write_reg(ntcc_pkg::REG_THRESH, 16'($urandom_range(0, 65535)));
        random_burst(120, 0);
        drain();

        $display("covered %0d samples, %0d results: %0d singular, %0d collisions, %0d saturated",
                 n_beats_in, n_beats_out, n_sing, n_coll, n_sat);
        if (n_err == 0 && pending.size() == 0) begin
            $display("tb_nullspace_torque_collision_check_top: clean");
        end else begin
            $display("tb_nullspace_torque_collision_check_top: errors");
        end
        $finish;
    end
endmodule

// ===== nullspace_torque_collision_check_top.f =====
rtl/ntcc_pkg.sv
rtl/ntcc_front.sv
rtl/ntcc_queue.sv
rtl/ntcc_back.sv
rtl/nullspace_torque_collision_check_top.sv
bench/tb_nullspace_torque_collision_check_top.sv
